// ----- rtl/ps2_mouse_packet_tracker_core_defines.svh -----
// Assertion macros used by the packet tracker back end
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_DEFINES_SVH

// clocked property, checked outside reset
`define PS2MPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold
`define PS2MPT_NEVER(lbl, cond, msg) \
  `PS2MPT_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/ps2mpt_pkg.sv -----
// Shared types and constants of the PS/2 mouse packet tracker
`timescale 1ns / 1ps
package ps2mpt_pkg;

  localparam int SYNC_BIT  = 3;
  localparam int LEFT_BIT  = 0;
  localparam int RIGHT_BIT = 1;

  localparam logic [11:0] RESET_X      = 12'd512;
  localparam logic [11:0] RESET_Y      = 12'd384;
  localparam logic [12:0] RESET_WIDTH  = 13'd1024;
  localparam logic [12:0] RESET_HEIGHT = 13'd768;
  localparam logic [11:0] POS_MAX      = 12'd4095;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       left;
    logic       right;
    logic [7:0] x_delta;
    logic [7:0] y_delta;
  } pkt_t;

endpackage

// ----- rtl/ps2mpt_front.sv -----
// Front end: byte sync and three-byte packet assembly
`timescale 1ns / 1ps
module ps2mpt_front
  import ps2mpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       push,
  output pkt_t       push_pkt
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XBYTE  = 2'd1,
    PH_YBYTE  = 2'd2
  } phase_t;

  phase_t     phase;
  logic [7:0] header_byte;
  logic [7:0] x_delta_byte;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (phase == PH_YBYTE);

  assign push_pkt.left    = header_byte[LEFT_BIT];
  assign push_pkt.right   = header_byte[RIGHT_BIT];
  assign push_pkt.x_delta = x_delta_byte;
  assign push_pkt.y_delta = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_byte  <= '0;
      x_delta_byte <= '0;
    end else if (accept) begin
      case (phase)
        PH_XBYTE: begin
          x_delta_byte <= rx_byte;
          phase        <= PH_YBYTE;
        end
        PH_YBYTE: begin
          phase <= PH_HEADER;
        end
        default: begin
          if (rx_byte[SYNC_BIT]) begin
            header_byte <= rx_byte;
            phase       <= PH_XBYTE;
          end else begin
            phase <= PH_HEADER;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/ps2mpt_queue.sv -----
// Short packet queue between front and back ends
`timescale 1ns / 1ps
module ps2mpt_queue
  import ps2mpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_pkt,
  output logic full,
  input  logic pop,
  output logic avail,
  output pkt_t pop_pkt
);

  pkt_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign pop_pkt = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/ps2mpt_back.sv -----
// Back end: cursor move, clamp, button events and output register
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_core_defines.svh"
module ps2mpt_back
  import ps2mpt_pkg::*;
#(
  parameter int MARGIN_X = 24,
  parameter int MARGIN_Y = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [12:0] screen_width,
  input  logic [12:0] screen_height,
  input  logic        avail,
  input  pkt_t        pkt,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] cursor_x,
  output logic [11:0] cursor_y,
  output logic        left_press,
  output logic        right_press,
  output logic        left_drag,
  output logic        left_release
);

  function automatic logic [11:0] clamp_axis(logic signed [13:0] p, logic [12:0] size,
                                             logic [6:0] margin);
    logic signed [14:0] lim;
    logic signed [14:0] pe;
    logic [11:0]        res;
    lim = $signed({2'b00, size}) - $signed({8'b0, margin});
    pe  = 15'(p);
    if (lim < 0) begin
      lim = '0;
    end else if (lim > $signed({3'b000, POS_MAX})) begin
      lim = $signed({3'b000, POS_MAX});
    end
    if (pe < 0) begin
      res = '0;
    end else if (pe >= lim) begin
      res = lim[11:0];
    end else begin
      res = pe[11:0];
    end
    return res;
  endfunction

  logic [11:0]        pos_x;
  logic [11:0]        pos_y;
  logic               left_was_down;
  logic               right_was_down;
  logic signed [13:0] dx;
  logic signed [13:0] dy;
  logic signed [13:0] nx;
  logic signed [13:0] ny;
  logic [11:0]        pos_x_next;
  logic [11:0]        pos_y_next;

  assign pop = avail && (!out_valid || !out_stall);

  always_comb begin
    dx         = 14'($signed(pkt.x_delta));
    dy         = 14'($signed(pkt.y_delta));
    nx         = $signed({2'b00, pos_x}) + (dx <<< 1) + dx;
    ny         = $signed({2'b00, pos_y}) - ((dy <<< 1) + dy);
    pos_x_next = clamp_axis(nx, screen_width, 7'(MARGIN_X));
    pos_y_next = clamp_axis(ny, screen_height, 7'(MARGIN_Y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      pos_x          <= RESET_X;
      pos_y          <= RESET_Y;
      left_was_down  <= 1'b0;
      right_was_down <= 1'b0;
    end else if (pop) begin
      out_valid      <= 1'b1;
      pos_x          <= pos_x_next;
      pos_y          <= pos_y_next;
      left_was_down  <= pkt.left;
      right_was_down <= pkt.right;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cursor_x     <= pos_x_next;
      cursor_y     <= pos_y_next;
      left_press   <= pkt.left && !left_was_down;
      right_press  <= pkt.right && !right_was_down;
      left_drag    <= pkt.left && left_was_down;
      left_release <= !pkt.left && left_was_down;
    end
  end

  `PS2MPT_ASSERT(a_hold_pos, (out_valid && out_stall) |=> ($stable(pos_x) && $stable(pos_y)), "position moved under stall")
  `PS2MPT_ASSERT(a_pop_shows, pop |=> (out_valid && cursor_x == pos_x && cursor_y == pos_y), "result not shown after pop")
  `PS2MPT_NEVER(a_left_excl, out_valid && (left_press + left_drag + left_release) > 2'd1, "left events overlap")

endmodule

// ----- rtl/ps2_mouse_packet_tracker_core.sv -----
// Top level of the PS/2 mouse packet tracker
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid, in_stall, rx_byte): one mouse byte per beat. Bytes
//   whose bit 3 is clear are dropped while waiting for a packet header; then
//   the next two bytes are taken as x and y movement.
//   Output channel (out_valid, out_stall, cursor_x, cursor_y and the button
//   events): one beat per completed three-byte packet, none for other bytes.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is the
//   screen width, index 1 the screen height; always ready, write while idle.
//   Throughput: one byte per cycle while in_stall is low, set by the byte
//   assembler and the combinational move and clamp in the back end.
//   Result path: the packet enters the queue as its third byte is accepted,
//   then moves to the output register once the output is free.
//   Stall: out_stall holds the result; the queue absorbs two more packets,
//   after which in_stall rises until the output moves on.
//   Reset: cursor at 512, 384, buttons up, screen 1024 by 768, sync lost.
module ps2_mouse_packet_tracker_core
  import ps2mpt_pkg::*;
#(
  parameter int MARGIN_X = 24,
  parameter int MARGIN_Y = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] cursor_x,
  output logic [11:0] cursor_y,
  output logic        left_press,
  output logic        right_press,
  output logic        left_drag,
  output logic        left_release,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic        push;
  pkt_t        push_pkt;
  logic        q_full;
  logic        pop;
  logic        avail;
  pkt_t        pop_pkt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default:           screen_width  <= screen_width;
      endcase
    end
  end

  ps2mpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_pkt (push_pkt)
  );

  ps2mpt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .pop      (pop),
    .avail    (avail),
    .pop_pkt  (pop_pkt)
  );

  ps2mpt_back #(
    .MARGIN_X (MARGIN_X),
    .MARGIN_Y (MARGIN_Y)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .avail         (avail),
    .pkt           (pop_pkt),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .left_press    (left_press),
    .right_press   (right_press),
    .left_drag     (left_drag),
    .left_release  (left_release)
  );

endmodule

// ----- tb/testbench.sv -----
// Testbench for the PS/2 mouse packet tracker: byte driver, result monitor and cursor predictor
`timescale 1ns / 1ps
module testbench;
  import ps2mpt_pkg::*;

  localparam int MARGIN_X   = 24;
  localparam int MARGIN_Y   = 32;
  localparam int MOVE_SCALE = 3;
  localparam int CYCLE_CAP  = 400000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_BYTES = 191;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        lp;
    logic        rp;
    logic        ld;
    logic        lr;
  } cursor_rep_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic        left_press;
  logic        right_press;
  logic        left_drag;
  logic        left_release;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_SCREEN_WIDTH;
  logic [12:0] cfg_data = 13'd0;

  logic [7:0]  mouse_byte_q[$];
  cursor_rep_t cursor_due_q[$];

  logic [1:0]  pkt_phase = 2'd0;
  logic [7:0]  hdr_byte = 8'h00;
  logic [7:0]  dx_byte = 8'h00;
  logic [11:0] pos_x = RESET_X;
  logic [11:0] pos_y = RESET_Y;
  logic        left_down = 1'b0;
  logic        right_down = 1'b0;
  logic [12:0] scr_width = RESET_WIDTH;
  logic [12:0] scr_height = RESET_HEIGHT;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  logic [7:0] opening [21] = '{
    8'h00, 8'hF7,
    8'h08, 8'h7F, 8'h80,
    8'h09, 8'h7F, 8'h80,
    8'h0B, 8'h80, 8'h7F,
    8'h08, 8'h80, 8'h7F,
    8'hFF, 8'h00, 8'h01,
    8'h0A, 8'hFF, 8'hFF,
    8'h37
  };

  ps2_mouse_packet_tracker_core #(
    .MARGIN_X(MARGIN_X),
    .MARGIN_Y(MARGIN_Y)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_x(cursor_x),
    .cursor_y(cursor_y),
    .left_press(left_press),
    .right_press(right_press),
    .left_drag(left_drag),
    .left_release(left_release),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [11:0] bound_axis(int p, logic [12:0] size, int margin);
    int lim;
    lim = int'(size) - margin;
    if (lim < 0) lim = 0;
    if (lim > int'(POS_MAX)) lim = int'(POS_MAX);
    if (p < 0) p = 0;
    if (p >= lim) p = lim;
    return p[11:0];
  endfunction

  task automatic track_byte(input logic [7:0] b);
    int nx;
    int ny;
    logic lft;
    logic rgt;
    cursor_rep_t rep;
    if (pkt_phase == 2'd1) begin
      dx_byte = b;
      pkt_phase = 2'd2;
    end else if (pkt_phase != 2'd2) begin
      if (!b[SYNC_BIT]) begin
        pkt_phase = 2'd0;
      end else begin
        hdr_byte = b;
        pkt_phase = 2'd1;
      end
    end else begin
      nx = int'(pos_x) + int'($signed(dx_byte)) * MOVE_SCALE;
      ny = int'(pos_y) - int'($signed(b)) * MOVE_SCALE;
      lft = hdr_byte[LEFT_BIT];
      rgt = hdr_byte[RIGHT_BIT];
      pos_x = bound_axis(nx, scr_width, MARGIN_X);
      pos_y = bound_axis(ny, scr_height, MARGIN_Y);
      rep.x = pos_x;
      rep.y = pos_y;
      rep.lp = lft && !left_down;
      rep.rp = rgt && !right_down;
      rep.ld = lft && left_down;
      rep.lr = !lft && left_down;
      cursor_due_q.push_back(rep);
      left_down = lft;
      right_down = rgt;
      pkt_phase = 2'd0;
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (mouse_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= mouse_byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    cursor_rep_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cursor_due_q.size() == 0) begin
          $display("%0t: unexpected result x %0d y %0d events %b%b%b%b", $time, cursor_x,
                   cursor_y, left_press, right_press, left_drag, left_release);
          errors++;
        end else begin
          want = cursor_due_q.pop_front();
          check_field("cursor_x", int'(want.x), int'(cursor_x));
          check_field("cursor_y", int'(want.y), int'(cursor_y));
          check_field("left_press", int'(want.lp), int'(left_press));
          check_field("right_press", int'(want.rp), int'(right_press));
          check_field("left_drag", int'(want.ld), int'(left_drag));
          check_field("left_release", int'(want.lr), int'(left_release));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_screen_reg(input logic idx, input logic [12:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) scr_width = val;
    else scr_height = val;
  endtask

  task automatic settle();
    while (mouse_byte_q.size() != 0 || in_valid || cursor_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_random_bytes(input int n);
    int sent;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 80) begin
        mouse_byte_q.push_back(8'($urandom_range(255)) | 8'h08);
        mouse_byte_q.push_back(8'($urandom_range(255)));
        mouse_byte_q.push_back(8'($urandom_range(255)));
        sent += 3;
      end else if (r < 90) begin
        mouse_byte_q.push_back(8'($urandom_range(255)));
        sent++;
      end else begin
        mouse_byte_q.push_back(8'($urandom_range(255)) & 8'hF7);
        sent++;
      end
    end
  endtask

  initial begin
    logic [12:0] w;
    logic [12:0] h;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 82;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 82;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct = 28;
        end
      endcase
      case (ph)
        1: begin w = 13'd32;   h = 13'd32;   end
        2: begin w = 13'd4096; h = 13'd4096; end
        3: begin w = 13'd8191; h = 13'd8191; end
        4: begin w = 13'd0;    h = 13'd0;    end
        5: begin w = 13'd20;   h = 13'd40;   end
        6: begin
          w = 13'($urandom_range(32, 4096));
          h = 13'($urandom_range(32, 4096));
        end
        default: begin
          w = 13'($urandom_range(8191));
          h = 13'($urandom_range(8191));
        end
      endcase
      if (ph == 0) begin
        foreach (opening[i]) mouse_byte_q.push_back(opening[i]);
      end else begin
        write_screen_reg(CFG_SCREEN_WIDTH, w);
        write_screen_reg(CFG_SCREEN_HEIGHT, h);
      end
      queue_random_bytes(PHASE_BYTES);
    end
    settle();
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
